### rtl/core/b64d_pkg.sv
// ---------------------------------------------------------------------------
// b64d_pkg - shared types and helpers for the Base64 stream decoder
// Status codes, the bundle of results made by one character and the
// alphabet lookup.
// ---------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam int         MAX_RESULTS = 3;
  localparam int         IDX_W       = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_PAD  = 2'd2,
    ST_CHAR = 2'd3
  } status_t;

  // Results caused by one accepted character, packed so that the elements
  // 0..last are sent in order.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [IDX_W-1:0]            last;
    logic                        has_bytes;
    logic                        fin;
    status_t                     status;
  } bundle_t;

  // Bit 6 set marks a character outside the selected alphabet.
  function automatic logic [6:0] char_value(input logic [7:0] c, input logic url);
    logic [7:0] d;
    logic [6:0] v;
    d = 8'h00;
    v = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      v = {1'b0, d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
      v = {1'b0, d[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
      v = {1'b0, d[5:0]};
    end else if (url) begin
      if (c == 8'h2D) v = 7'd62;
      else if (c == 8'h5F) v = 7'd63;
    end else begin
      if (c == 8'h2B) v = 7'd62;
      else if (c == 8'h2F) v = 7'd63;
    end
    return v;
  endfunction

endpackage

### rtl/core/b64d_char_if.sv
// ---------------------------------------------------------------------------
// b64d_char_if - character channel
// Valid/ready channel carrying one encoded character and its final flag.
// ---------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

### rtl/core/b64d_byte_if.sv
// ---------------------------------------------------------------------------
// b64d_byte_if - decoded byte channel
// Valid/ready channel carrying one decoded byte with status and end flag.
// ---------------------------------------------------------------------------
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       end_of_run;

  modport source (output valid, output data_byte, output byte_valid, output status,
                  output end_of_run, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input status,
                  input end_of_run, output ready);
endinterface

### rtl/core/b64d_group.sv
// ---------------------------------------------------------------------------
// b64d_group - group assembly
// Tracks the position in the group of four, the collected sextets and the
// first error, and builds the bundle of results for each character.
// ---------------------------------------------------------------------------
module b64d_group (
  input  logic              clk,
  input  logic              rst,
  input  logic              url,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              is_final,
  output logic              push,
  output b64d_pkg::bundle_t bundle
);
  import b64d_pkg::*;

  logic [1:0]  group_position, group_position_next;
  logic [17:0] sextet_store, sextet_store_next;
  logic        third_was_pad, third_was_pad_next;
  status_t     latched_error, latched_error_next;

  always_comb begin
    logic       is_pad;
    logic [6:0] cv;
    logic [5:0] val;
    logic [5:0] s0, s1, s2;
    logic [7:0] b0, b1, b2;

    is_pad = (char_code == PAD_CHAR);
    cv     = char_value(char_code, url);
    val    = 6'd0;
    latched_error_next = latched_error;
    if (is_pad) begin
      if (group_position < 2'd2 && latched_error == ST_OK) latched_error_next = ST_PAD;
    end else if (cv[6]) begin
      if (latched_error == ST_OK) latched_error_next = ST_CHAR;
    end else begin
      val = cv[5:0];
    end

    s0 = sextet_store[17:12];
    s1 = sextet_store[11:6];
    s2 = sextet_store[5:0];
    b0 = {s0, s1[5:4]};
    b1 = {s1[3:0], s2[5:2]};
    b2 = {s2[1:0], val};

    bundle.bytes[0]  = b0;
    bundle.bytes[1]  = third_was_pad ? b2 : b1;
    bundle.bytes[2]  = b2;
    bundle.has_bytes = (group_position == 2'd3) && (latched_error_next == ST_OK);
    bundle.last      = {1'b0, ~third_was_pad} + {1'b0, ~is_pad};
    bundle.fin       = is_final;
    bundle.status    = ST_OK;

    if (group_position != 2'd3) begin
      sextet_store_next   = {sextet_store[11:0], val};
      third_was_pad_next  = (group_position == 2'd2) ? is_pad : third_was_pad;
      group_position_next = group_position + 2'd1;
    end else begin
      sextet_store_next   = 18'd0;
      third_was_pad_next  = 1'b0;
      group_position_next = 2'd0;
    end

    if (is_final) begin
      // Length error overrides everything and drops the bytes
      bundle.status       = (group_position != 2'd3) ? ST_LEN : latched_error_next;
      group_position_next = 2'd0;
      sextet_store_next   = 18'd0;
      third_was_pad_next  = 1'b0;
      latched_error_next  = ST_OK;
    end

    if (!bundle.has_bytes) bundle.last = '0;
    push = accept && (is_final || bundle.has_bytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      sextet_store   <= 18'd0;
      third_was_pad  <= 1'b0;
      latched_error  <= ST_OK;
    end else if (accept) begin
      group_position <= group_position_next;
      sextet_store   <= sextet_store_next;
      third_was_pad  <= third_was_pad_next;
      latched_error  <= latched_error_next;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    accept && is_final |=> group_position == 2'd0 && latched_error == ST_OK)
    else $error("state not cleared after final character");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    latched_error != ST_OK && !(accept && is_final) |=>
      latched_error == $past(latched_error))
    else $error("latched error changed before end of string");

  a_bytes_on_group_end: assert property (@(posedge clk) disable iff (rst)
    push && bundle.has_bytes |-> group_position == 2'd3 && latched_error_next == ST_OK)
    else $error("bytes produced outside a completed group");

endmodule

### rtl/core/b64d_serializer.sv
// ---------------------------------------------------------------------------
// b64d_serializer - result queue and output register
// Holds up to two bundles and sends their results one per transfer.
// ---------------------------------------------------------------------------
module b64d_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64d_pkg::bundle_t bundle,
  output logic              can_take,
  b64d_byte_if.source       out_ch
);
  import b64d_pkg::*;

  bundle_t          slot0, slot1;
  logic [1:0]       cnt;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             load, pop, last_elem;

  assign last_elem = (idx == slot0.last);
  assign load      = (cnt != 2'd0) && (!out_valid || out_ch.ready);
  assign pop       = load && last_elem;
  assign can_take  = (cnt != 2'd2) || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 2'd0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= pop ? '0 : idx + 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  // Queue payload; advance on pop, fill the first free slot on push
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= slot1;
      if (push) begin
        if (cnt == 2'd1) slot0 <= bundle;
        else slot1 <= bundle;
      end
    end else if (push) begin
      if (cnt == 2'd0) slot0 <= bundle;
      else slot1 <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.data_byte  <= slot0.has_bytes ? slot0.bytes[idx] : 8'd0;
      out_ch.byte_valid <= slot0.has_bytes;
      out_ch.end_of_run <= slot0.fin && last_elem;
      out_ch.status     <= (slot0.fin && last_elem) ? slot0.status : ST_OK;
    end
  end

  assign out_ch.valid = out_valid;

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd0 |-> idx <= slot0.last)
    else $error("element index beyond bundle");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 |-> idx == '0)
    else $error("element index not reset on empty queue");

  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.byte_valid |-> out_ch.end_of_run)
    else $error("byteless result that does not end the run");

  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.status != ST_OK |-> out_ch.end_of_run)
    else $error("status reported before end of run");

endmodule

### rtl/core/base64_stream_decoder.sv
// ---------------------------------------------------------------------------
// base64_stream_decoder - streaming Base64 decoder
// Decodes one character per transfer into bytes, with end-of-run status.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one character per transfer, is_final on the last one of a string.
//   out_ch : one decoded byte per transfer; the last transfer of a string has
//            end_of_run set and carries the status (ok, bad length, misplaced
//            padding, invalid character). A string with no bytes to give ends
//            in a single transfer with byte_valid low.
//   cfg_wr_en/cfg_wr_data : write url_alphabet (0 standard, 1 URL-safe); write
//            only while no string is in flight.
// Path: the bundle of the character that completes a group or ends the
//   string is queued at its transfer; its first result then passes through
//   the output register before it transfers.
// Throughput: one character per cycle while the queue has room. A completed
//   group gives up to three results, sent from a two-bundle queue through the
//   single output register at one result per cycle while out_ch.ready is high.
// Reset: clears the group position, sextet store, latched error, queue and
//   output register, and selects the standard alphabet.
// Stall: when out_ch.ready is low the output register holds its result, the
//   queue fills, and in_ch.ready drops once both bundle slots are taken.
// ---------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  b64d_char_if.sink   in_ch,
  b64d_byte_if.source out_ch
);
  import b64d_pkg::*;

  logic    url_alphabet;
  logic    accept;
  logic    push;
  logic    can_take;
  bundle_t bundle;

  // Alphabet select register
  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
    end else if (cfg_wr_en) begin
      url_alphabet <= cfg_wr_data;
    end
  end

  // Take a character whenever the queue has room for its results
  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  b64d_group u_group (
    .clk       (clk),
    .rst       (rst),
    .url       (url_alphabet),
    .accept    (accept),
    .char_code (in_ch.char_code),
    .is_final  (in_ch.is_final),
    .push      (push),
    .bundle    (bundle)
  );

  b64d_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .bundle   (bundle),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule

### sim/base64_stream_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_decoder_test - self-checking bench for the Base64 decoder
// Feeds encoded strings in both alphabets: hand-picked groups first, then
// random strings that are mostly well formed, with a share of broken ones.
// A bit-accurate decoder inside the bench predicts every output transfer,
// which is checked field by field in arrival order. Both channels idle at
// random.
// ---------------------------------------------------------------------------
module base64_stream_decoder_test;
  import b64d_pkg::*;

  // Special characters of the two alphabets.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // One character waiting to be sent; hold makes the sender wait until
  // every predicted byte has been collected before offering it.
  typedef struct {
    logic [7:0] code;
    logic       fin;
    bit         hold;
  } char_item_t;

  // One predicted output transfer.
  typedef struct {
    logic [7:0] data;
    logic       vld;
    status_t    status;
    logic       eor;
  } byte_res_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  b64d_char_if in_if ();
  b64d_byte_if out_if ();

  base64_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  char_item_t char_q[$];    // characters not yet transferred
  byte_res_t  result_q[$];  // predicted bytes not yet collected
  int         mismatches = 0;
  bit         calm;         // when set, neither side idles

  // Predictor state: mirrors the decoder's group position, gathered sextets,
  // pad flag of the third character, first error and alphabet select.
  logic       url_sel;
  logic [1:0] grp_pos;
  logic [17:0] sextets;
  logic       third_pad;
  status_t    held_err;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly back-to-back, now and then a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Character for a 6-bit value in the chosen alphabet.
  function automatic logic [7:0] enc_char(input int idx, input logic url);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + (idx - 26));
    if (idx < 62) return 8'(8'h30 + (idx - 52));
    if (idx == 62) return url ? CH_DASH : CH_PLUS;
    return url ? CH_UNDER : CH_SLASH;
  endfunction

  // 6-bit value of a character; bit 6 flags a character outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
    if (c == (url ? CH_DASH : CH_PLUS)) return 7'd62;
    if (c == (url ? CH_UNDER : CH_SLASH)) return 7'd63;
    return 7'h40;
  endfunction

  task automatic clear_group();
    grp_pos   = 2'd0;
    sextets   = '0;
    third_pad = 1'b0;
    held_err  = ST_OK;
  endtask

  // Advance the predictor by one transferred character and queue the bytes
  // it yields.
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [1:0] pos;
    logic       pad;
    logic [6:0] v;
    logic [5:0] val;
    status_t    st;
    byte_res_t  res[$];
    pos = grp_pos;
    pad = (c == PAD_CHAR);
    val = '0;
    if (pad) begin
      // Padding in the first two places of a group is misplaced.
      if (pos < 2 && held_err == ST_OK) held_err = ST_PAD;
    end else begin
      v = sextet_of(c, url_sel);
      if (v[6]) begin
        if (held_err == ST_OK) held_err = ST_CHAR;
      end else begin
        val = v[5:0];
      end
    end
    if (pos != 2'd3) begin
      if (pos == 2'd2) third_pad = pad;
      sextets = {sextets[11:0], val};
      grp_pos = pos + 2'd1;
    end else begin
      // Group complete: give its bytes unless an error is held; a pad in the
      // third or fourth place drops its own byte only.
      if (held_err == ST_OK) begin
        res.push_back('{{sextets[17:12], sextets[11:10]}, 1'b1, ST_OK, 1'b0});
        if (!third_pad)
          res.push_back('{{sextets[9:6], sextets[5:2]}, 1'b1, ST_OK, 1'b0});
        if (!pad)
          res.push_back('{{sextets[1:0], val}, 1'b1, ST_OK, 1'b0});
      end
      grp_pos   = 2'd0;
      sextets   = '0;
      third_pad = 1'b0;
    end
    if (fin) begin
      // A short final group overrides any held error and gives no bytes.
      if (pos != 2'd3) begin
        st = ST_LEN;
        res.delete();
      end else begin
        st = held_err;
      end
      if (res.size() == 0) res.push_back('{8'h00, 1'b0, ST_OK, 1'b0});
      res[res.size()-1].status = st;
      res[res.size()-1].eor    = 1'b1;
      clear_group();
    end
    foreach (res[i]) result_q.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    byte_res_t want;
    if (result_q.size() == 0) begin
      report_mismatch("unexpected transfer", out_if.data_byte, 8'h00);
      return;
    end
    want = result_q.pop_front();
    if (out_if.data_byte !== want.data)
      report_mismatch("data_byte", out_if.data_byte, want.data);
    if (out_if.byte_valid !== want.vld)
      report_mismatch("byte_valid", 8'(out_if.byte_valid), 8'(want.vld));
    if (out_if.status !== want.status)
      report_mismatch("status", 8'(out_if.status), 8'(want.status));
    if (out_if.end_of_run !== want.eor)
      report_mismatch("end_of_run", 8'(out_if.end_of_run), 8'(want.eor));
  endtask

  // Character driver: offer the head of char_q, then idle for a random gap.
  // A held character waits on an idle cycle until nothing is outstanding.
  int src_idle;
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid     <= 1'b0;
      in_if.char_code <= 8'h00;
      in_if.is_final  <= 1'b0;
      src_idle        <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) void'(char_q.pop_front());
      if (src_idle != 0) begin
        src_idle    <= src_idle - 1;
        in_if.valid <= 1'b0;
      end else if (char_q.size() != 0 &&
                   (!char_q[0].hold || (!in_if.valid && result_q.size() == 0))) begin
        in_if.valid     <= 1'b1;
        in_if.char_code <= char_q[0].code;
        in_if.is_final  <= char_q[0].fin;
        src_idle        <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: collect output transfers, predict from input transfers, track
  // alphabet writes and stall the output at random. Check before predicting
  // so the order within the edge is fixed.
  int snk_idle;
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      snk_idle     <= 0;
      url_sel      = 1'b0;
      clear_group();
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (in_if.valid && in_if.ready) decode_char(in_if.char_code, in_if.is_final);
      if (cfg_wr_en) url_sel = cfg_wr_data;
      if (snk_idle != 0) begin
        snk_idle     <= snk_idle - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        snk_idle     <= pick_gap();
      end
    end
  end

  // Queue a string; the last character carries the final flag.
  task automatic push_chars(input logic [7:0] txt[$], input bit hold);
    foreach (txt[i]) char_q.push_back('{txt[i], i == txt.size() - 1, hold && i == 0});
  endtask

  task automatic push_text(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    push_chars(txt, 1'b0);
  endtask

  // Queue one random string; most are well formed, the rest carry a stray
  // byte, a short length, misplaced padding, a foreign special or raw noise.
  task automatic add_random_string(input logic url, input bit hold, output int count);
    int         groups;
    int         kind;
    int         idx;
    logic [7:0] txt[$];
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (int i = 0; i < groups * 4; i++) txt.push_back(enc_char($urandom_range(0, 63), url));
    case ($urandom_range(0, 3))
      1: txt[txt.size()-1] = PAD_CHAR;
      2: begin
        txt[txt.size()-1] = PAD_CHAR;
        txt[txt.size()-2] = PAD_CHAR;
      end
      default: ;
    endcase
    // Pad inside an earlier group now and then.
    if (groups > 1 && $urandom_range(0, 5) == 0) txt[$urandom_range(0, groups - 2) * 4 + 3] = PAD_CHAR;
    kind = $urandom_range(0, 13);
    case (kind)
      0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      1: repeat ($urandom_range(1, 3)) if (txt.size() > 1) void'(txt.pop_back());
      2: txt[$urandom_range(0, groups - 1) * 4 + $urandom_range(0, 1)] = PAD_CHAR;
      3: begin
        idx = $urandom_range(0, txt.size() - 1);
        if (url) txt[idx] = $urandom_range(0, 1) ? CH_PLUS : CH_SLASH;
        else     txt[idx] = $urandom_range(0, 1) ? CH_DASH : CH_UNDER;
      end
      4: begin
        txt.delete();
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    push_chars(txt, hold);
    count = txt.size();
  endtask

  task automatic add_random_phase(input logic url, input int target, input bit with_hold);
    int sent;
    int n;
    int strings;
    sent    = 0;
    strings = 0;
    while (sent < target) begin
      add_random_string(url, with_hold && strings == 1, n);
      sent += n;
      strings++;
    end
  endtask

  // Wait until every character is sent and every byte collected, then let
  // the decoder settle before the alphabet may change.
  task automatic wait_idle();
    do @(posedge clk);
    while (char_q.size() != 0 || in_if.valid || result_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_alphabet(input logic url);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= url;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    calm             = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Standard alphabet straight from reset: padding inside an earlier
    // group with a one-byte tail, both specials, pad third with a real
    // fourth, misplaced padding and a short string.
    push_text("QQ==+/+/");
    push_text("QU=B");
    push_text("A=AA");
    push_text("ABC");
    add_random_phase(1'b0, 30, 1'b0);
    wait_idle();

    // URL-safe alphabet: hand-picked strings with no idling at all, then
    // random traffic with one hold-off until the output has drained.
    write_alphabet(1'b1);
    calm = 1'b1;
    push_text("-_z9");
    push_text("AB+/");
    wait_idle();
    calm = 1'b0;
    add_random_phase(1'b1, 35, 1'b1);
    wait_idle();

    // Back to the standard alphabet.
    write_alphabet(1'b0);
    add_random_phase(1'b0, 30, 1'b0);
    wait_idle();
    repeat (10) @(posedge clk);

    if (result_q.size() != 0) report_mismatch("bytes never sent", 8'(result_q.size()), 8'h00);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### base64_stream_decoder.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_char_if.sv
rtl/core/b64d_byte_if.sv
rtl/core/b64d_group.sv
rtl/core/b64d_serializer.sv
rtl/core/base64_stream_decoder.sv
sim/base64_stream_decoder_test.sv
